// ===== sv/ccl2_pkg.sv =====
package ccl2_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 7;
  localparam int EPS_W      = 16;
  localparam int SQ_W       = 37;
  localparam int DOT_W      = 38;
  localparam int S_W        = 38;
  localparam int ROOT_W     = 32;
  localparam int NUM_W      = 64;
  localparam int QUO_W      = 32;
  localparam int VAL_W      = 34;
  localparam int PROD_W     = SAMPLE_W + QUO_W;
  localparam int SQRT_SHIFT = NUM_W - S_W;
  localparam int DIV_SHIFT  = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 2'd2;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPS_RESET   = 16'd1678;

  localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-(1 << (SAMPLE_W - 1)));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] grad_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value_out;
    logic                       is_last;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   data;
  } cfg_req_t;

  typedef struct packed {
    logic                    bank;
    logic [CNT_W-1:0]        count;
    logic                    mode;
    logic [S_W-1:0]          s;
    logic signed [DOT_W-1:0] dot;
  } job_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] used;
  } jobq_stat_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [S_W-1:0]   den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_PDIV,
    ST_PWAIT,
    ST_RD,
    ST_LOAD,
    ST_AWAIT,
    ST_MUL,
    ST_BDIV,
    ST_BWAIT,
    ST_EMIT
  } back_state_t;

endpackage

// ===== sv/ccl2_mem.sv =====
module ccl2_mem #(
  parameter int ADDR_W = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  ccl2_pkg::in_item_t   wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output ccl2_pkg::in_item_t   rdata
);
  import ccl2_pkg::*;

  in_item_t mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ccl2_div.sv =====
module ccl2_div (
  input  logic                      clk,
  input  logic                      rst,
  input  ccl2_pkg::div_req_t        req,
  output logic                      busy,
  output logic                      done,
  output logic [ccl2_pkg::QUO_W-1:0] quo
);
  import ccl2_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [S_W:0]       rem;
  logic [S_W:0]       rem_sh;
  logic [S_W:0]       rem_next;
  logic [S_W-1:0]     den;
  logic [QUO_W-1:0]   num_lo;
  logic [QUO_W-1:0]   q;
  logic [STEP_W-1:0]  steps;
  logic               zero;
  logic               take;

  always_comb begin
    rem_sh   = {rem[S_W-1:0], num_lo[QUO_W-1]};
    take     = rem_sh >= {1'b0, den};
    rem_next = take ? rem_sh - {1'b0, den} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(QUO_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem    <= (S_W+1)'(req.num[NUM_W-1:QUO_W]);
      num_lo <= req.num[QUO_W-1:0];
      den    <= req.den;
      zero   <= req.den == '0;
      q      <= '0;
    end else if (busy) begin
      rem    <= rem_next;
      num_lo <= {num_lo[QUO_W-2:0], 1'b0};
      q      <= {q[QUO_W-2:0], take};
    end
  end

  assign quo = zero ? '0 : q;

endmodule

// ===== sv/ccl2_front.sv =====
module ccl2_front #(
  parameter int MAX_CHANNELS = 64,
  parameter int IDX_W        = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ccl2_pkg::cfg_req_t     cfg,
  input  logic                   push,
  input  ccl2_pkg::in_item_t     item,
  output logic                   full,
  output logic                   mem_we,
  output logic [IDX_W:0]         mem_waddr,
  output ccl2_pkg::in_item_t     mem_wdata,
  output ccl2_pkg::job_t         job,
  output logic                   job_valid,
  input  logic                   job_pop,
  output ccl2_pkg::jobq_stat_t   stat
);
  import ccl2_pkg::*;

  logic                        mode;
  logic [CNT_W-1:0]            count;
  logic [EPS_W-1:0]            eps;
  logic [CNT_W-1:0]            cnt_act;
  logic [IDX_W-1:0]            idx;
  logic                        bank;
  logic                        accept;
  logic                        last;
  logic signed [2*SAMPLE_W-1:0] sq_w;
  logic signed [2*SAMPLE_W-1:0] pr_w;

  logic                        st_valid;
  logic                        st_last;
  logic [2*SAMPLE_W-1:0]       st_sq;
  logic signed [2*SAMPLE_W-1:0] st_pr;
  logic                        st_mode;
  logic [EPS_W-1:0]            st_eps;
  logic [CNT_W-1:0]            st_cnt;
  logic                        st_bank;

  logic [SQ_W-1:0]             sumsq;
  logic signed [DOT_W-1:0]     dot;
  logic [SQ_W-1:0]             sumsq_next;
  logic signed [DOT_W-1:0]     dot_next;

  job_t                        jq [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  used;
  logic                        jq_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_FWD;
      count <= COUNT_RESET;
      eps   <= EPS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:  mode  <= cfg.data[0];
        REG_COUNT: count <= cfg.data[CNT_W-1:0];
        REG_EPS:   eps   <= cfg.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count == '0) begin
      cnt_act = CNT_W'(1);
    end else if (count > CNT_W'(MAX_CHANNELS)) begin
      cnt_act = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_act = count;
    end
  end

  assign jq_push = st_valid && st_last;
  assign full    = (used == 2'd2) || ((used == 2'd1) && jq_push);
  assign accept  = push && !full;
  assign last    = (CNT_W'(idx) + CNT_W'(1)) >= cnt_act;
  assign sq_w    = item.sample_in * item.sample_in;
  assign pr_w    = item.sample_in * item.grad_in;

  assign mem_we    = accept;
  assign mem_waddr = {bank, idx};
  assign mem_wdata = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      bank     <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      st_valid <= accept;
      if (accept) begin
        if (last) begin
          idx  <= '0;
          bank <= !bank;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_last <= last;
      st_sq   <= sq_w;
      st_pr   <= pr_w;
      st_mode <= mode;
      st_eps  <= eps;
      st_cnt  <= cnt_act;
      st_bank <= bank;
    end
  end

  assign sumsq_next = sumsq + SQ_W'(st_sq);
  assign dot_next   = dot + DOT_W'(st_pr);

  always_ff @(posedge clk) begin
    if (rst) begin
      sumsq <= '0;
      dot   <= '0;
    end else if (st_valid) begin
      if (st_last) begin
        sumsq <= '0;
        dot   <= '0;
      end else begin
        sumsq <= sumsq_next;
        dot   <= dot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (jq_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (jq_push && !job_pop) begin
        used <= used + 2'd1;
      end else if (!jq_push && job_pop) begin
        used <= used - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (jq_push) begin
      jq[wr_ptr] <= '{bank:  st_bank,
                      count: st_cnt,
                      mode:  st_mode,
                      s:     S_W'(sumsq_next) + S_W'(st_eps),
                      dot:   dot_next};
    end
  end

  assign job       = jq[rd_ptr];
  assign job_valid = used != 2'd0;
  assign stat      = '{push: jq_push, pop: job_pop, used: used};

endmodule

// ===== sv/ccl2_back.sv =====
module ccl2_back #(
  parameter int IDX_W = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ccl2_pkg::job_t             job,
  input  logic                       job_valid,
  output logic                       job_pop,
  output logic [IDX_W:0]             rd_addr,
  input  ccl2_pkg::in_item_t         rd_data,
  output ccl2_pkg::div_req_t         div_req,
  input  logic                       div_done,
  input  logic [ccl2_pkg::QUO_W-1:0] div_quo,
  input  logic                       pop,
  output logic                       empty,
  output ccl2_pkg::out_item_t        result
);
  import ccl2_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  logic [CNT_W-1:0]        k;
  logic                    k_last;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W+2:0]       rem;
  logic [ROOT_W+2:0]       rem_sh;
  logic [ROOT_W+2:0]       trial;
  logic                    sq_take;
  logic [NUM_W-1:0]        vsh;
  logic [4:0]              iter;
  logic [QUO_W-1:0]        p_mag;
  logic                    p_neg;
  logic [SAMPLE_W-1:0]     x_mag;
  logic                    x_neg;
  logic                    src_neg;
  logic signed [VAL_W-1:0] acc;
  logic [PROD_W-1:0]       prod;
  logic                    out_valid;
  logic                    load;
  logic [DOT_W-1:0]        dot_mag;
  logic signed [SAMPLE_W-1:0] src;
  logic [SAMPLE_W-1:0]     src_mag;
  logic [SAMPLE_W-1:0]     smp_mag;
  logic signed [VAL_W-1:0] quo_s;
  logic                    sat_hi;
  logic                    sat_lo;

  assign k_last  = (k + CNT_W'(1)) == job.count;
  assign rem_sh  = {rem[ROOT_W:0], vsh[NUM_W-1:NUM_W-2]};
  assign trial   = (ROOT_W+3)'({root, 2'b01});
  assign sq_take = rem_sh >= trial;
  assign dot_mag = job.dot[DOT_W-1] ? DOT_W'(-job.dot) : DOT_W'(job.dot);
  assign src     = (job.mode == MODE_BWD) ? rd_data.grad_in : rd_data.sample_in;
  assign src_mag = src[SAMPLE_W-1] ? SAMPLE_W'(-src) : SAMPLE_W'(src);
  assign smp_mag = rd_data.sample_in[SAMPLE_W-1] ? SAMPLE_W'(-rd_data.sample_in)
                                                  : SAMPLE_W'(rd_data.sample_in);
  assign quo_s   = $signed(VAL_W'(div_quo));
  assign sat_hi  = acc > SAT_HI;
  assign sat_lo  = acc < SAT_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load       = 1'b0;
    div_req    = '0;
    rd_addr    = {job.bank, k[IDX_W-1:0]};
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (iter == '0) begin
          state_next = (job.mode == MODE_BWD) ? ST_PDIV : ST_RD;
        end
      end
      ST_PDIV: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'({dot_mag, {DIV_SHIFT{1'b0}}}) + NUM_W'(root >> 1);
        div_req.den   = S_W'(root);
        state_next    = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (div_done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'({src_mag, {DIV_SHIFT{1'b0}}}) + NUM_W'(root >> 1);
        div_req.den   = S_W'(root);
        state_next    = ST_AWAIT;
      end
      ST_AWAIT: begin
        if (div_done) begin
          state_next = (job.mode == MODE_BWD) ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        state_next = ST_BDIV;
      end
      ST_BDIV: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(prod) + NUM_W'(job.s >> 1);
        div_req.den   = job.s;
        state_next    = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || pop) begin
          load = 1'b1;
          if (k_last) begin
            job_pop    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        root <= '0;
        rem  <= '0;
        vsh  <= {job.s, {SQRT_SHIFT{1'b0}}};
        iter <= 5'd31;
        k    <= '0;
      end
      ST_SQRT: begin
        rem  <= sq_take ? rem_sh - trial : rem_sh;
        root <= {root[ROOT_W-2:0], sq_take};
        vsh  <= {vsh[NUM_W-3:0], 2'b00};
        iter <= iter - 5'd1;
      end
      ST_PWAIT: begin
        if (div_done) begin
          p_mag <= div_quo;
          p_neg <= job.dot[DOT_W-1];
        end
      end
      ST_LOAD: begin
        x_mag   <= smp_mag;
        x_neg   <= rd_data.sample_in[SAMPLE_W-1];
        src_neg <= src[SAMPLE_W-1];
      end
      ST_AWAIT: begin
        if (div_done) begin
          acc <= src_neg ? -quo_s : quo_s;
        end
      end
      ST_MUL: begin
        prod <= x_mag * p_mag;
      end
      ST_BWAIT: begin
        if (div_done) begin
          acc <= (x_neg ^ p_neg) ? acc + quo_s : acc - quo_s;
        end
      end
      ST_EMIT: begin
        if (load) begin
          k <= k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.is_last   <= k_last;
      result.saturated <= sat_hi || sat_lo;
      if (sat_hi) begin
        result.value_out <= SAT_HI[SAMPLE_W-1:0];
      end else if (sat_lo) begin
        result.value_out <= SAT_LO[SAMPLE_W-1:0];
      end else begin
        result.value_out <= acc[SAMPLE_W-1:0];
      end
    end
  end

  assign empty = !out_valid;

endmodule

// ===== sv/cross_channel_l2_normalize_core.sv =====
// Cross-channel L2 normalization of one pixel vector at a time.
// Configuration: write mode, channel count or epsilon through cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// Input: one request per channel, taken when push is high and full is low. The
// front stores the sample and gradient in a two-bank buffer and accumulates the
// sum of squares and the gradient dot product, one sample per cycle when not full.
// A finished vector goes into a two-deep job queue; full rises when both banks
// hold vectors that the back end has not finished.
// Back end per vector: a bit-serial square root, in backward mode one division
// for the dot term, then per channel one division in forward mode and two in
// backward mode, all on the shared 32-step divider.
// Results come out in channel order through a one-entry output register; while
// empty is low and pop is low the result holds and the back end waits. Reset
// clears the job queue, the front counters and accumulators and the back-end
// state and output valid, and loads the register defaults (forward mode, 64
// channels, epsilon 1678); buffer contents are kept.
module cross_channel_l2_normalize_core #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccl2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccl2_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               push,
  output logic                               full,
  input  ccl2_pkg::in_item_t                 item,
  output logic                               empty,
  input  logic                               pop,
  output ccl2_pkg::out_item_t                result
);
  import ccl2_pkg::*;

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_req_t          cfg;
  logic              mem_we;
  logic [IDX_W:0]    mem_waddr;
  in_item_t          mem_wdata;
  logic [IDX_W:0]    rd_addr;
  in_item_t          rd_data;
  job_t              job;
  logic              job_valid;
  logic              job_pop;
  jobq_stat_t        stat;
  div_req_t          div_req;
  logic              div_busy;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;

  assign cfg_ready = 1'b1;
  assign cfg       = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

  ccl2_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .item      (item),
    .full      (full),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .stat      (stat)
  );

  ccl2_mem #(
    .ADDR_W (IDX_W + 1)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ccl2_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  ccl2_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  a_jobq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.push |-> stat.used != 2'd2)
    else $error("job pushed into a full queue");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.saturated) |->
      (result.value_out == SAT_HI[SAMPLE_W-1:0] || result.value_out == SAT_LO[SAMPLE_W-1:0]))
    else $error("saturated result not at a rail");

endmodule
